// ===== hw/rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefixed deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int unsigned MAX_LENGTH_BITS = 25;
    localparam int unsigned PAYLOAD_LENGTH_BITS = 24;

    localparam logic [MAX_LENGTH_BITS-1:0] MAX_LENGTH_RESET = 25'd65536;

    // header byte positions
    localparam logic [3:0] HDR_LEN_LAST_IDX = 4'd3;
    localparam logic [3:0] HDR_WORD_BYTES   = 4'd4;
    localparam logic [3:0] HDR_ID_END       = 4'd8;
    localparam logic [3:0] HDR_LAST_IDX     = 4'd11;

    // bytes of the length field taken by the two ids
    localparam logic [31:0] ID_BYTES = 32'd8;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef struct packed {
        logic                           valid;
        logic [1:0]                     kind;
        logic [31:0]                    msg_id;
        logic [31:0]                    seq_id;
        logic [PAYLOAD_LENGTH_BITS-1:0] payload_length;
        logic [7:0]                     payload_byte;
        logic                           last;
    } lpd_result_t;

endpackage

// ===== hw/rtl/length_prefixed_deframer_top.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Splits a byte stream into frames with a 12-byte big-endian header (length,
// message id, sequence id). Takes one byte per cycle while not stalled and
// gives at most one result per byte: a header result after the twelfth
// header byte, one result per payload byte, or a single length error after
// which all bytes are dropped until reset. A byte passes an input register
// and the result register before its result appears; the sustained rate is
// one byte per cycle while the output is not stalled, as the header shifters
// and payload counter update on every accepted byte. The input register
// keeps a held byte while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_COUNT_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [MAX_LENGTH_BITS-1:0]     cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [31:0]                    msg_id,
    output logic [31:0]                    seq_id,
    output logic [PAYLOAD_LENGTH_BITS-1:0] payload_length,
    output logic [7:0]                     payload_byte,
    output logic                           last
);

    logic [MAX_LENGTH_BITS-1:0] max_length_reg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    lpd_result_t                out_reg;
    lpd_result_t                result;
    logic                       advance;
    logic                       step;

    assign advance  = !out_reg.valid || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    lpd_core #(
        .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .max_length (max_length_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write_en)
        begin
            max_length_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_reg.valid;
    assign kind           = out_reg.kind;
    assign msg_id         = out_reg.msg_id;
    assign seq_id         = out_reg.seq_id;
    assign payload_length = out_reg.payload_length;
    assign payload_byte   = out_reg.payload_byte;
    assign last           = out_reg.last;

    a_error_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> last && msg_id == '0 && payload_length == '0)
        else $error("error result with wrong fields");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register changed while stalled");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_reg))
        else $error("result register changed while stalled");

endmodule

// ===== hw/rtl/lpd_core.sv =====
// ----------------------------------------------------------------------------
// lpd_core
// Frame parser state: header shifters, length check, payload countdown.
// Produces the result of the byte presented while step is high.
// ----------------------------------------------------------------------------
module lpd_core
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_COUNT_BITS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic [MAX_LENGTH_BITS-1:0] max_length,
    output lpd_result_t                result
);

    localparam logic [32:0] CountLimit = (33'd1 << LENGTH_COUNT_BITS) - 33'd1;
    localparam logic [LENGTH_COUNT_BITS-1:0] RemainOne = LENGTH_COUNT_BITS'(1);

    phase_t                       phase_reg, phase_next;
    logic [3:0]                   header_byte_count_reg, header_byte_count_next;
    logic [31:0]                  length_shift_reg, length_shift_next;
    logic [31:0]                  msg_id_shift_reg, msg_id_shift_next;
    logic [31:0]                  seq_id_shift_reg, seq_id_shift_next;
    logic [LENGTH_COUNT_BITS-1:0] payload_remaining_reg, payload_remaining_next;

    logic [31:0] len_word;
    logic [31:0] len_diff;
    logic        len_bad;
    logic [31:0] plen;
    logic        plen_zero;
    logic        remain_last;

    assign len_word    = {length_shift_reg[23:0], data_byte};
    assign len_diff    = len_word - ID_BYTES;
    assign len_bad     = (len_word < ID_BYTES)
                      || (len_word > {7'd0, max_length})
                      || ({1'b0, len_diff} > CountLimit);
    assign plen        = length_shift_reg - ID_BYTES;
    assign plen_zero   = (length_shift_reg == ID_BYTES);
    assign remain_last = (payload_remaining_reg <= RemainOne);

    always_comb
    begin
        phase_next             = phase_reg;
        header_byte_count_next = header_byte_count_reg;
        length_shift_next      = length_shift_reg;
        msg_id_shift_next      = msg_id_shift_reg;
        seq_id_shift_next      = seq_id_shift_reg;
        payload_remaining_next = payload_remaining_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_byte_count_reg < HDR_WORD_BYTES)
                    begin
                        length_shift_next = len_word;
                    end
                    else if (header_byte_count_reg < HDR_ID_END)
                    begin
                        msg_id_shift_next = {msg_id_shift_reg[23:0], data_byte};
                    end
                    else
                    begin
                        seq_id_shift_next = {seq_id_shift_reg[23:0], data_byte};
                    end

                    if (header_byte_count_reg == HDR_LEN_LAST_IDX && len_bad)
                    begin
                        phase_next             = PH_ERROR;
                        header_byte_count_next = 4'd0;
                    end
                    else if (header_byte_count_reg >= HDR_LAST_IDX)
                    begin
                        header_byte_count_next = 4'd0;
                        if (plen_zero)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else
                        begin
                            phase_next             = PH_PAYLOAD;
                            payload_remaining_next = plen[LENGTH_COUNT_BITS-1:0];
                        end
                    end
                    else
                    begin
                        header_byte_count_next = header_byte_count_reg + 4'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remain_last)
                    begin
                        payload_remaining_next = '0;
                        phase_next             = PH_HEADER;
                    end
                    else
                    begin
                        payload_remaining_next = payload_remaining_reg - RemainOne;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        result = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_byte_count_reg == HDR_LEN_LAST_IDX && len_bad)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_ERROR;
                        result.last  = 1'b1;
                    end
                    else if (header_byte_count_reg >= HDR_LAST_IDX)
                    begin
                        result.valid          = 1'b1;
                        result.kind           = KIND_HEADER;
                        result.msg_id         = msg_id_shift_reg;
                        result.seq_id         = {seq_id_shift_reg[23:0], data_byte};
                        result.payload_length = plen[PAYLOAD_LENGTH_BITS-1:0];
                        result.last           = plen_zero;
                    end
                end
                PH_PAYLOAD:
                begin
                    result.valid        = 1'b1;
                    result.kind         = KIND_PAYLOAD;
                    result.payload_byte = data_byte;
                    result.last         = remain_last;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HEADER;
            header_byte_count_reg <= 4'd0;
            length_shift_reg      <= '0;
            msg_id_shift_reg      <= '0;
            seq_id_shift_reg      <= '0;
            payload_remaining_reg <= '0;
        end
        else
        begin
            phase_reg             <= phase_next;
            header_byte_count_reg <= header_byte_count_next;
            length_shift_reg      <= length_shift_next;
            msg_id_shift_reg      <= msg_id_shift_next;
            seq_id_shift_reg      <= seq_id_shift_next;
            payload_remaining_reg <= payload_remaining_next;
        end
    end

    a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_remaining_reg != '0)
        else $error("payload phase with zero bytes remaining");

    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> header_byte_count_reg <= HDR_LAST_IDX)
        else $error("header byte count out of range");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_ERROR |=> phase_reg == PH_ERROR)
        else $error("length error did not enter sticky error");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> !result.valid && phase_next == PH_ERROR)
        else $error("sticky error produced a result or left error");

endmodule
